### sv/nrsu_pkg.sv
// shared types, constants and helpers for the row smoothing upsampler
package nrsu_pkg;

  localparam int PixW   = 8;
  localparam int OctW   = 3;
  localparam int KW     = 5;
  localparam int WtW    = 16;
  localparam int WtFrac = 16;
  localparam logic [OctW-1:0] OctMax = 3'd5;

  typedef logic [PixW-1:0] pix_t;
  typedef logic [OctW-1:0] oct_t;
  typedef logic [KW-1:0]   kidx_t;
  typedef logic [WtW-1:0]  wt_t;

  // raised-cosine weights, q0.16
  localparam wt_t COS_WEIGHT [32] = '{
    16'd0,     16'd158,   16'd630,   16'd1411,  16'd2494,  16'd3869,  16'd5522,  16'd7438,
    16'd9598,  16'd11980, 16'd14563, 16'd17321, 16'd20228, 16'd23256, 16'd26375, 16'd29556,
    16'd32768, 16'd35980, 16'd39161, 16'd42280, 16'd45308, 16'd48215, 16'd50973, 16'd53556,
    16'd55938, 16'd58098, 16'd60014, 16'd61667, 16'd63042, 16'd64125, 16'd64906, 16'd65378
  };

  // one request's work: the inner segment and the wrap segment
  typedef struct packed {
    logic seg_a_en;
    pix_t seg_a_v0;
    pix_t seg_a_v1;
    logic seg_b_en;
    pix_t seg_b_v0;
    pix_t seg_b_v1;
  } job_t;

  function automatic oct_t clamp_octave(input oct_t oct);
    clamp_octave = (oct > OctMax) ? OctMax : oct;
  endfunction

endpackage

### sv/nrsu_in_if.sv
// input channel: one 3x3 neighbourhood request per coarse point
interface nrsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] up_left;
  logic [7:0] up;
  logic [7:0] up_right;
  logic [7:0] left;
  logic [7:0] center;
  logic [7:0] right;
  logic [7:0] down_left;
  logic [7:0] down;
  logic [7:0] down_right;
  logic       last_point;

  modport source (
    output valid, up_left, up, up_right, left, center, right,
           down_left, down, down_right, last_point,
    input  ready
  );
  modport sink (
    input  valid, up_left, up, up_right, left, center, right,
           down_left, down, down_right, last_point,
    output ready
  );
endinterface

### sv/nrsu_out_if.sv
// output channel: one pixel request per cycle while ready is high
interface nrsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel;
  logic       last;

  modport source (output valid, pixel, last, input ready);
  modport sink (input valid, pixel, last, output ready);
endinterface

### sv/nrsu_smooth.sv
// 3x3 smoothing of one coarse point
module nrsu_smooth import nrsu_pkg::*; (
  input  pix_t up_left,
  input  pix_t up,
  input  pix_t up_right,
  input  pix_t left,
  input  pix_t center,
  input  pix_t right,
  input  pix_t down_left,
  input  pix_t down,
  input  pix_t down_right,
  output pix_t smoothed
);

  logic [9:0] edge_sum;
  logic [9:0] corner_sum;
  logic [9:0] total;

  always_comb begin
    edge_sum   = 10'(up) + 10'(down) + 10'(left) + 10'(right);
    corner_sum = 10'(up_left) + 10'(up_right) + 10'(down_left) + 10'(down_right);
    total      = 10'(center >> 2) + (edge_sum >> 3) + (corner_sum >> 4);
  end

  assign smoothed = total[7:0];

endmodule

### sv/nrsu_segment_gen.sv
// segment sequencer, cosine blend and output register
module nrsu_segment_gen import nrsu_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  oct_t             octave,
  input  logic             load,
  input  job_t             job,
  output logic             can_load,
  nrsu_out_if.source       out_ch
);

  logic  busy_r, busy_nxt;
  logic  cur_b_r, cur_b_nxt;
  kidx_t k_r, k_nxt;
  job_t  job_r, job_nxt;
  logic  out_valid_r, out_valid_nxt;
  pix_t  pixel_r, pixel_nxt;
  logic  last_r, last_nxt;

  oct_t  oct;
  kidx_t k_max;
  kidx_t w_idx;
  wt_t   w;
  logic  advance, seg_end, job_end;
  pix_t  v0, v1;
  logic signed [8:0]  diff;
  logic signed [25:0] prod;
  logic [9:0]         blend;

  always_comb begin
    oct     = clamp_octave(octave);
    k_max   = KW'((6'd1 << oct) - 6'd1);
    w_idx   = KW'(k_r << (3'd5 - oct));
    w       = COS_WEIGHT[w_idx];
    advance = busy_r && (!out_valid_r || out_ch.ready);
    seg_end = (k_r == k_max);
    job_end = seg_end && (cur_b_r || !job_r.seg_b_en);
    v0      = cur_b_r ? job_r.seg_b_v0 : job_r.seg_a_v0;
    v1      = cur_b_r ? job_r.seg_b_v1 : job_r.seg_a_v1;
    // v0 + floor((v1 - v0) * w / 2^16) equals the weighted sum form exactly
    diff    = $signed({1'b0, v1}) - $signed({1'b0, v0});
    prod    = diff * $signed({1'b0, w});
    blend   = {2'b00, v0} + 10'(prod >>> WtFrac);
  end

  assign can_load = !busy_r || (advance && job_end);

  always_comb begin
    busy_nxt = busy_r;
    cur_b_nxt = cur_b_r;
    k_nxt = k_r;
    job_nxt = job_r;
    if (advance) begin
      if (seg_end) begin
        k_nxt = '0;
        if (job_end) begin
          busy_nxt = 1'b0;
        end else begin
          cur_b_nxt = 1'b1;
        end
      end else begin
        k_nxt = k_r + 1'b1;
      end
    end
    if (load) begin
      job_nxt   = job;
      busy_nxt  = job.seg_a_en || job.seg_b_en;
      cur_b_nxt = !job.seg_a_en;
      k_nxt     = '0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    pixel_nxt = pixel_r;
    last_nxt = last_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
      pixel_nxt     = blend[7:0];
      last_nxt      = job_end;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      cur_b_r     <= 1'b0;
      k_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      cur_b_r     <= cur_b_nxt;
      k_r         <= k_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    pixel_r <= pixel_nxt;
    last_r  <= last_nxt;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.pixel = pixel_r;
  assign out_ch.last  = last_r;

endmodule

### sv/noise_row_smooth_upsample_unit.sv
// top level of the row smoothing and cosine upsampling unit
// Each request on in_ch is the 3x3 neighbourhood of one coarse point of a
// circular row, in row order. The point is smoothed (centre/4 + edges/8 +
// corners/16) as it is taken, and the row state is updated the same cycle.
// Every point after the first yields 2^octave pixels on out_ch, one per
// cycle while out_ch is not stalled, from the previous smoothed value towards
// this one; the point flagged last_point also yields the wrap segment back to
// the row's first point, and the final pixel of each request carries last.
// The first point of a row gives no pixels unless it is also its last point.
// Throughput is set by the single blend unit, one pixel a cycle unless out_ch
// stalls. The next request is taken in the cycle its predecessor's final
// pixel is formed, and the output register decouples the two sides. octave
// is written through cfg_we / cfg_wdata; the user must do so only while the
// unit is idle, which the block does not enforce; values above 5 act as 5.
module noise_row_smooth_upsample_unit import nrsu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  oct_t        cfg_wdata,
  nrsu_in_if.sink     in_ch,
  nrsu_out_if.source  out_ch
);

  // configuration
  oct_t octave_r;

  // row state
  pix_t first_r, first_nxt;
  pix_t prev_r, prev_nxt;
  logic have_first_r, have_first_nxt;

  pix_t smoothed;
  pix_t first_eff;
  logic accept;
  logic can_load;
  job_t job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      octave_r <= '0;
    end else if (cfg_we) begin
      octave_r <= cfg_wdata;
    end
  end

  nrsu_smooth u_smooth (
    .up_left    (in_ch.up_left),
    .up         (in_ch.up),
    .up_right   (in_ch.up_right),
    .left       (in_ch.left),
    .center     (in_ch.center),
    .right      (in_ch.right),
    .down_left  (in_ch.down_left),
    .down       (in_ch.down),
    .down_right (in_ch.down_right),
    .smoothed   (smoothed)
  );

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  // a single-point row wraps onto itself
  assign first_eff = have_first_r ? first_r : smoothed;

  always_comb begin
    job.seg_a_en = have_first_r;
    job.seg_a_v0 = prev_r;
    job.seg_a_v1 = smoothed;
    job.seg_b_en = in_ch.last_point;
    job.seg_b_v0 = smoothed;
    job.seg_b_v1 = first_eff;
  end

  always_comb begin
    first_nxt      = first_r;
    prev_nxt       = prev_r;
    have_first_nxt = have_first_r;
    if (accept) begin
      if (!have_first_r) begin
        first_nxt = smoothed;
      end
      prev_nxt       = smoothed;
      // end of row starts a fresh row on the next request
      have_first_nxt = !in_ch.last_point;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r      <= '0;
      prev_r       <= '0;
      have_first_r <= 1'b0;
    end else begin
      first_r      <= first_nxt;
      prev_r       <= prev_nxt;
      have_first_r <= have_first_nxt;
    end
  end

  nrsu_segment_gen u_seg (
    .clk      (clk),
    .rst_n    (rst_n),
    .octave   (octave_r),
    .load     (accept),
    .job      (job),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

  // row state follows the request stream
  a_row_end: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.last_point) |=> !have_first_r)
    else $error("row state not cleared after last point");

  a_row_open: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_ch.last_point) |=> have_first_r)
    else $error("row not open after a non-final point");

  a_first_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !have_first_r) |=> (first_r == $past(smoothed)))
    else $error("first smoothed value not captured");

  a_prev_kept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (prev_r == $past(smoothed)))
    else $error("previous smoothed value not captured");

endmodule

### dv/tb_noise_row_smooth_upsample_unit.sv
`timescale 1ns / 100ps
// self-checking testbench for the row smoothing and cosine upsampling unit
module tb_noise_row_smooth_upsample_unit;
  import nrsu_pkg::*;

  // run limits, in clock cycles
  localparam int unsigned CYCLE_LIMIT   = 400000;
  // longest request is 64 pixels, plus the output register and a margin
  localparam int unsigned SETTLE_CYCLES = 80;
  // long output stall that lets the unit fill up and push back on its input
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned PHASE_POINTS  = 19;
  localparam real         PI            = 3.14159265358979323846;
  localparam oct_t        OCT_LIMIT     = 3'd5;

  // one coarse point as it travels on the input channel
  typedef struct packed {
    pix_t up_left, up, up_right;
    pix_t left, center, right;
    pix_t down_left, down, down_right;
    logic last_point;
  } point_t;

  // one pixel as it should leave the output channel
  typedef struct packed {
    pix_t pixel;
    logic last;
  } due_pixel_t;

  // tracks the row state and the pixels each accepted point should produce
  class row_pixel_tracker;
    int unsigned raised_cos [32];
    oct_t        octave;
    pix_t        first_level;
    pix_t        prev_level;
    bit          row_open;
    due_pixel_t  pixels_due [$];
    int unsigned faults;

    function new();
      for (int k = 0; k < 32; k++) begin
        raised_cos[k] = $rtoi(32768.0 * (1.0 - $cos(PI * real'(k) / 32.0)) + 0.5);
      end
      octave      = '0;
      first_level = '0;
      prev_level  = '0;
      row_open    = 1'b0;
      faults      = 0;
    endfunction

    task report_fault(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      faults++;
    endtask

    function void set_octave(input oct_t value);
      octave = value;
    endfunction

    function int unsigned pending();
      return pixels_due.size();
    endfunction

    // centre/4 + edges/8 + corners/16, each term truncated on its own
    function pix_t smooth(input point_t p);
      int unsigned edges, corners, total;
      edges   = int'(p.up) + int'(p.left) + int'(p.right) + int'(p.down);
      corners = int'(p.up_left) + int'(p.up_right) + int'(p.down_left) + int'(p.down_right);
      total   = int'(p.center) / 4 + edges / 8 + corners / 16;
      return pix_t'(total);
    endfunction

    function pix_t blend(input pix_t v0, input pix_t v1, input int unsigned w);
      int unsigned acc;
      acc = int'(v0) * (65536 - w) + int'(v1) * w;
      return pix_t'(acc >> 16);
    endfunction

    // 2^span pixels from v0 towards v1, first one is v0 itself
    function int unsigned push_segment(input pix_t v0, input pix_t v1, input oct_t span);
      int unsigned steps;
      due_pixel_t  d;
      steps = 1 << span;
      for (int unsigned k = 0; k < steps; k++) begin
        d.pixel = (k == 0) ? v0 : blend(v0, v1, raised_cos[(k << (5 - span)) & 31]);
        d.last  = 1'b0;
        pixels_due.push_back(d);
      end
      return steps;
    endfunction

    function void take_point(input point_t p);
      pix_t        level;
      oct_t        span;
      int unsigned added;
      due_pixel_t  tail;
      level = smooth(p);
      span  = (octave > OCT_LIMIT) ? OCT_LIMIT : octave;
      added = 0;
      if (!row_open) begin
        first_level = level;
        row_open    = 1'b1;
      end else begin
        added += push_segment(prev_level, level, span);
      end
      prev_level = level;
      if (p.last_point) begin
        added   += push_segment(level, first_level, span);
        row_open = 1'b0;
      end
      if (added != 0) begin
        tail      = pixels_due.pop_back();
        tail.last = 1'b1;
        pixels_due.push_back(tail);
      end
    endfunction

    task match_pixel(input pix_t pixel, input logic last);
      due_pixel_t d;
      if (pixels_due.size() == 0) begin
        report_fault($sformatf("pixel %0d arrived with nothing outstanding", pixel));
      end else begin
        d = pixels_due.pop_front();
        if (d.pixel !== pixel)
          report_fault($sformatf("pixel %0d, wanted %0d", pixel, d.pixel));
        if (d.last !== last)
          report_fault($sformatf("last %b on pixel %0d, wanted %b", last, pixel, d.last));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  oct_t cfg_wdata;

  nrsu_in_if  in_ch ();
  nrsu_out_if out_ch ();

  row_pixel_tracker tracker;
  bit               long_hold_wanted;

  noise_row_smooth_upsample_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // gap lengths: mostly none or short, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 95) return $urandom_range(10, 4);
    return $urandom_range(60, 20);
  endfunction

  // bytes lean towards the extremes so the smoothing sums hit their limits
  function automatic pix_t rand_byte();
    case ($urandom_range(9, 0))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return pix_t'($urandom_range(255, 0));
    endcase
  endfunction

  function automatic point_t rand_point(input bit last_point);
    point_t p;
    p.up_left    = rand_byte();
    p.up         = rand_byte();
    p.up_right   = rand_byte();
    p.left       = rand_byte();
    p.center     = rand_byte();
    p.right      = rand_byte();
    p.down_left  = rand_byte();
    p.down       = rand_byte();
    p.down_right = rand_byte();
    p.last_point = last_point;
    return p;
  endfunction

  // the centre, every edge and every corner take the value given for their group
  function automatic point_t make_point(input pix_t c, input pix_t e, input pix_t k,
                                        input bit last_point);
    point_t p;
    p.center     = c;
    p.up         = e;
    p.left       = e;
    p.right      = e;
    p.down       = e;
    p.up_left    = k;
    p.up_right   = k;
    p.down_left  = k;
    p.down_right = k;
    p.last_point = last_point;
    return p;
  endfunction

  // present one request and hold it until the unit takes it
  task automatic offer_point(input point_t p, input bit eager);
    int unsigned gap;
    in_ch.valid      <= 1'b1;
    in_ch.up_left    <= p.up_left;
    in_ch.up         <= p.up;
    in_ch.up_right   <= p.up_right;
    in_ch.left       <= p.left;
    in_ch.center     <= p.center;
    in_ch.right      <= p.right;
    in_ch.down_left  <= p.down_left;
    in_ch.down       <= p.down;
    in_ch.down_right <= p.down_right;
    in_ch.last_point <= p.last_point;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // valid stays high straight into the next request when there is no gap
    if (!eager) begin
      gap = gap_len();
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // mostly whole rows of random length, with a few broken row markers mixed in
  task automatic offer_random_rows(input int unsigned count, input bit eager);
    int unsigned sent;
    int unsigned row_len;
    point_t      p;
    sent = 0;
    while (sent < count) begin
      row_len = ($urandom_range(7, 0) == 0) ? 1 : $urandom_range(8, 2);
      for (int unsigned i = 0; i < row_len && sent < count; i++) begin
        p = rand_point(i == row_len - 1);
        if ($urandom_range(9, 0) == 0) p.last_point = 1'($urandom_range(1, 0));
        offer_point(p, eager);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // wait for every outstanding pixel, then for a first point still in flight
  task automatic settle();
    @(posedge clk);
    while (tracker.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_octave(input oct_t value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tracker.set_octave(value);
  endtask

  // input side: every accepted request updates the expected pixel stream
  always @(posedge clk) begin
    point_t p;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      p.up_left    = in_ch.up_left;
      p.up         = in_ch.up;
      p.up_right   = in_ch.up_right;
      p.left       = in_ch.left;
      p.center     = in_ch.center;
      p.right      = in_ch.right;
      p.down_left  = in_ch.down_left;
      p.down       = in_ch.down;
      p.down_right = in_ch.down_right;
      p.last_point = in_ch.last_point;
      tracker.take_point(p);
    end
  end

  // output side: each accepted pixel is checked against the oldest expected one
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      tracker.match_pixel(out_ch.pixel, out_ch.last);
    end
  end

  // receiver: bursts of ready, random stalls, and one long hold when asked
  initial begin : pixel_sink
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_wanted) begin
        long_hold_wanted = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(2, 0) == 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(40, 1)) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : stimulus
    oct_t phase_oct [8];
    phase_oct = '{3'd3, 3'd1, 3'd6, 3'd4, 3'd2, 3'd5, 3'd0, 3'd7};
    tracker          = new();
    long_hold_wanted = 1'b0;

    rst_n            <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    in_ch.valid      <= 1'b0;
    in_ch.up_left    <= '0;
    in_ch.up         <= '0;
    in_ch.up_right   <= '0;
    in_ch.left       <= '0;
    in_ch.center     <= '0;
    in_ch.right      <= '0;
    in_ch.down_left  <= '0;
    in_ch.down       <= '0;
    in_ch.down_right <= '0;
    in_ch.last_point <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // octave zero straight from reset: single-point row, then each term of
    // the smoothing alone and alternating bit patterns
    offer_point(make_point(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
    offer_point(make_point(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    offer_point(make_point(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
    offer_point(make_point(8'hFF, 8'h00, 8'h00, 1'b0), 1'b0);
    offer_point(make_point(8'h00, 8'hFF, 8'h00, 1'b0), 1'b0);
    offer_point(make_point(8'h00, 8'h00, 8'hFF, 1'b0), 1'b0);
    offer_point(make_point(8'hAA, 8'hAA, 8'hAA, 1'b0), 1'b0);
    offer_point(make_point(8'h55, 8'h55, 8'h55, 1'b1), 1'b0);
    in_ch.valid <= 1'b0;
    settle();

    // widest spacing: full swings both ways and a single-point row
    write_octave(3'd5);
    offer_point(make_point(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    offer_point(make_point(8'hFF, 8'hFF, 8'hFF, 1'b0), 1'b0);
    offer_point(make_point(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    offer_point(make_point(8'hAA, 8'h55, 8'hAA, 1'b1), 1'b0);
    offer_point(make_point(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
    in_ch.valid <= 1'b0;
    settle();

    // register above the limit acts as the widest spacing
    write_octave(3'd7);
    offer_point(make_point(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
    offer_point(make_point(8'h00, 8'h00, 8'h00, 1'b0), 1'b0);
    offer_point(make_point(8'hFF, 8'hFF, 8'hFF, 1'b1), 1'b0);
    in_ch.valid <= 1'b0;
    settle();

    // random rows under each setting; the octave 5 and 6 phases run back to back,
    // the octave 5 one against a long output hold so the unit fills and stalls its input
    foreach (phase_oct[i]) begin
      write_octave(phase_oct[i]);
      if (phase_oct[i] == 3'd5) long_hold_wanted = 1'b1;
      offer_random_rows(PHASE_POINTS, phase_oct[i] == 3'd5 || i == 2);
      settle();
    end

    if (tracker.pending() != 0)
      tracker.report_fault($sformatf("%0d pixels never arrived", tracker.pending()));
    if (tracker.faults == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### noise_row_smooth_upsample_unit.f
sv/nrsu_pkg.sv
sv/nrsu_in_if.sv
sv/nrsu_out_if.sv
sv/nrsu_smooth.sv
sv/nrsu_segment_gen.sv
sv/noise_row_smooth_upsample_unit.sv
dv/tb_noise_row_smooth_upsample_unit.sv
